>>> rtl/core/pdc_pkg.sv
// Package for the PI duty controller with capture.
// Holds sizing constants, configuration register indexes, the sequencer
// state type and the command struct shared by the controller and datapath.
package pdc_pkg;

  localparam int WAVE_LENGTH    = 1000;
  localparam int DECIMATION     = 10;
  localparam int PLOT_POINTS    = 200;
  localparam int INTEGRAL_WIDTH = 24;

  localparam int ADC_W   = 10;
  localparam int GAIN_W  = 16;
  localparam int PER_W   = 16;
  localparam int CMP_W   = 16;
  localparam int IDX_W   = 8;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 16;

  localparam int POS_W  = $clog2(WAVE_LENGTH);
  localparam int HALF_WAVE = WAVE_LENGTH / 2;
  localparam int DEC_W  = $clog2(DECIMATION + 1);
  localparam int PLOT_W = $clog2(PLOT_POINTS + 1);

  localparam int ERR_W  = ADC_W + 1;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int IP_W   = GAIN_W + INTEGRAL_WIDTH;
  localparam int SUM_W  = IP_W + 1;

  localparam int DUTY_OFFSET_Q8 = 12800;
  localparam int DUTY_FULL_Q8   = 25600;
  localparam int DUTY_W         = 15;
  localparam int SC_W           = DUTY_W + PER_W;

  localparam int DIV_SHIFT = 32;
  localparam int RECIP_W   = 26;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd42949673;
  localparam int DIVX_W    = SC_W - 8;
  localparam int QP_W      = DIVX_W + RECIP_W;

  localparam logic [CFG_A_W-1:0] CFG_KP_GAIN    = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_KI_GAIN    = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_PWM_PERIOD = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_REF_HIGH   = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_REF_LOW    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DUTY,
    ST_SCALE,
    ST_DIV
  } pdc_state_e;

  typedef struct packed {
    logic accept;
    logic load_prod;
    logic load_duty;
    logic load_scale;
    logic load_out;
  } pdc_cmd_t;

endpackage

>>> rtl/core/pdc_ctrl.sv
// Sequencer for the PI duty controller.
// Steps one transaction through the datapath and owns the output valid flag.
// Depends on pdc_pkg.
module pdc_ctrl import pdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pdc_cmd_t cmd_o
);

  pdc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.load_prod = 1'b1;
        state_d         = ST_DUTY;
      end
      ST_DUTY: begin
        cmd_o.load_duty = 1'b1;
        state_d         = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.load_scale = 1'b1;
        state_d          = ST_DIV;
      end
      ST_DIV: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/pdc_datapath.sv
// Datapath for the PI duty controller: configuration registers, reference
// wave, saturating integral, capture bookkeeping and the duty arithmetic.
// Depends on pdc_pkg; driven by commands from pdc_ctrl.
module pdc_datapath import pdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdc_cmd_t           cmd_i,
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_idx_i,
  input  logic [CFG_D_W-1:0] cfg_wdata_i,
  input  logic [ADC_W-1:0]   adc_sample_i,
  input  logic               start_capture_i,
  output logic [CMP_W-1:0]   compare_value_o,
  output logic               capture_valid_o,
  output logic [IDX_W-1:0]   capture_index_o,
  output logic [ADC_W-1:0]   capture_adc_o,
  output logic [ADC_W-1:0]   capture_ref_o,
  output logic               capture_done_o
);

  logic signed [GAIN_W-1:0] kp_q, ki_q;
  logic [PER_W-1:0]         period_q;
  logic [ADC_W-1:0]         ref_high_q, ref_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      period_q   <= PER_W'(3999);
      ref_high_q <= ADC_W'(800);
      ref_low_q  <= ADC_W'(200);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KP_GAIN:    kp_q       <= cfg_wdata_i;
        CFG_KI_GAIN:    ki_q       <= cfg_wdata_i;
        CFG_PWM_PERIOD: period_q   <= cfg_wdata_i;
        CFG_REF_HIGH:   ref_high_q <= cfg_wdata_i[ADC_W-1:0];
        CFG_REF_LOW:    ref_low_q  <= cfg_wdata_i[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [POS_W-1:0]                pos_q, pos_d;
  logic signed [INTEGRAL_WIDTH-1:0] integ_q, integ_d;
  logic [DEC_W-1:0]                dec_q, dec_d;
  logic [PLOT_W-1:0]               plot_q, plot_d;
  logic                            capturing_q, capturing_d;

  logic [ADC_W-1:0]                ref_sel;
  logic signed [ERR_W-1:0]         err_s;
  logic signed [INTEGRAL_WIDTH:0]  integ_ext;
  logic                            start_eff;
  logic [DEC_W-1:0]                dec_base;
  logic [DEC_W-1:0]                dec_next;
  logic [PLOT_W-1:0]               plot_base;
  logic [PLOT_W-1:0]               plot_next;
  logic                            cap_hit, cap_done;

  always_comb begin
    ref_sel = (pos_q < POS_W'(HALF_WAVE)) ? ref_high_q : ref_low_q;
    err_s   = $signed({1'b0, ref_sel}) - $signed({1'b0, adc_sample_i});
    pos_d   = (pos_q == POS_W'(WAVE_LENGTH - 1)) ? '0 : pos_q + 1'b1;

    integ_ext = {integ_q[INTEGRAL_WIDTH-1], integ_q} + (INTEGRAL_WIDTH+1)'(err_s);
    if (integ_ext[INTEGRAL_WIDTH] != integ_ext[INTEGRAL_WIDTH-1]) begin
      integ_d = integ_ext[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                                          : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    end else begin
      integ_d = integ_ext[INTEGRAL_WIDTH-1:0];
    end

    start_eff = start_capture_i && !capturing_q;
    dec_base  = start_eff ? '0 : dec_q;
    plot_base = start_eff ? '0 : plot_q;
    dec_next  = dec_base + 1'b1;
    plot_next = plot_base + 1'b1;
    cap_hit   = 1'b0;
    cap_done  = 1'b0;
    dec_d       = dec_base;
    plot_d      = plot_base;
    capturing_d = capturing_q || start_eff;
    if (capturing_d) begin
      if (dec_next >= DEC_W'(DECIMATION)) begin
        dec_d   = '0;
        cap_hit = 1'b1;
        if (plot_next >= PLOT_W'(PLOT_POINTS)) begin
          plot_d      = '0;
          capturing_d = 1'b0;
          cap_done    = 1'b1;
        end else begin
          plot_d = plot_next;
        end
      end else begin
        dec_d = dec_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      integ_q     <= '0;
      dec_q       <= '0;
      plot_q      <= '0;
      capturing_q <= 1'b0;
    end else if (cmd_i.accept) begin
      pos_q       <= pos_d;
      integ_q     <= integ_d;
      dec_q       <= dec_d;
      plot_q      <= plot_d;
      capturing_q <= capturing_d;
    end
  end

  logic signed [ERR_W-1:0] err_q;
  logic                    cap_valid_q, cap_done_q;
  logic [IDX_W-1:0]        cap_idx_q;
  logic [ADC_W-1:0]        cap_adc_q, cap_ref_q;
  logic signed [PP_W-1:0]  pp_q;
  logic signed [IP_W-1:0]  ip_q;
  logic [DUTY_W-1:0]       duty_q, duty_d;
  logic signed [SUM_W-1:0] sum_s;
  logic [SC_W-1:0]         sc_q;
  logic [QP_W-1:0]         qp;

  always_comb begin
    sum_s = SUM_W'(pp_q) + SUM_W'(ip_q) + SUM_W'(DUTY_OFFSET_Q8);
    if (sum_s < 0) begin
      duty_d = '0;
    end else if (sum_s > SUM_W'(DUTY_FULL_Q8)) begin
      duty_d = DUTY_W'(DUTY_FULL_Q8);
    end else begin
      duty_d = sum_s[DUTY_W-1:0];
    end
    qp = QP_W'(sc_q[SC_W-1:8]) * QP_W'(DIV_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      err_q       <= err_s;
      cap_valid_q <= cap_hit;
      cap_done_q  <= cap_done;
      cap_idx_q   <= cap_hit ? IDX_W'(plot_base) : '0;
      cap_adc_q   <= cap_hit ? adc_sample_i : '0;
      cap_ref_q   <= cap_hit ? ref_sel : '0;
    end
    if (cmd_i.load_prod) begin
      pp_q <= kp_q * err_q;
      ip_q <= ki_q * integ_q;
    end
    if (cmd_i.load_duty) begin
      duty_q <= duty_d;
    end
    if (cmd_i.load_scale) begin
      sc_q <= SC_W'(duty_q) * SC_W'(period_q);
    end
    if (cmd_i.load_out) begin
      compare_value_o <= qp[DIV_SHIFT+CMP_W-1:DIV_SHIFT];
      capture_valid_o <= cap_valid_q;
      capture_index_o <= cap_idx_q;
      capture_adc_o   <= cap_adc_q;
      capture_ref_o   <= cap_ref_q;
      capture_done_o  <= cap_done_q;
    end
  end

endmodule

>>> rtl/core/pi_duty_controller_with_capture.sv
// Top level of the PI duty controller with decimated capture.
// Instantiates pdc_ctrl and pdc_datapath; depends on pdc_pkg.
//
// Each transaction is one control tick: a 10-bit converter sample goes in and
// one result comes out with the PWM compare value and, every tenth tick of a
// capture run, the sampled and reference pair with its index. After acceptance
// the sequencer runs the two gain products, the duty clamp, the period scaling
// and the reciprocal division by 25600 one after the other, loading the output
// registers in its last step. The input stalls while a tick is in progress, so
// a new transaction is taken only after the last one has loaded its output; a
// stalled result holds the sequencer in its last step until the waiting result
// is taken.
module pi_duty_controller_with_capture import pdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_idx_i,
  input  logic [CFG_D_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ADC_W-1:0]   adc_sample_i,
  input  logic               start_capture_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CMP_W-1:0]   compare_value_o,
  output logic               capture_valid_o,
  output logic [IDX_W-1:0]   capture_index_o,
  output logic [ADC_W-1:0]   capture_adc_o,
  output logic [ADC_W-1:0]   capture_ref_o,
  output logic               capture_done_o
);

  pdc_cmd_t cmd;

  pdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pdc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .adc_sample_i    (adc_sample_i),
    .start_capture_i (start_capture_i),
    .compare_value_o (compare_value_o),
    .capture_valid_o (capture_valid_o),
    .capture_index_o (capture_index_o),
    .capture_adc_o   (capture_adc_o),
    .capture_ref_o   (capture_ref_o),
    .capture_done_o  (capture_done_o)
  );

endmodule

>>> rtl/core/pdc_checker.sv
// Port-level checker for the PI duty controller with capture.
// Bound to pi_duty_controller_with_capture; depends on pdc_pkg.
module pdc_checker import pdc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CMP_W-1:0]   compare_value_o,
  input logic               capture_valid_o,
  input logic [IDX_W-1:0]   capture_index_o,
  input logic [ADC_W-1:0]   capture_adc_o,
  input logic [ADC_W-1:0]   capture_ref_o,
  input logic               capture_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(compare_value_o)
      && $stable(capture_valid_o) && $stable(capture_index_o))
    else $error("Stalled output transaction changed.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input accepted while a transaction is in progress.");

  a_done_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && capture_done_o |->
      capture_valid_o && capture_index_o == IDX_W'(PLOT_POINTS - 1))
    else $error("Capture completed without its final pair.");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !capture_valid_o |->
      capture_index_o == '0 && capture_adc_o == '0 && capture_ref_o == '0)
    else $error("Capture fields set without a stored pair.");

endmodule

bind pi_duty_controller_with_capture pdc_checker u_pdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .compare_value_o (compare_value_o),
  .capture_valid_o (capture_valid_o),
  .capture_index_o (capture_index_o),
  .capture_adc_o   (capture_adc_o),
  .capture_ref_o   (capture_ref_o),
  .capture_done_o  (capture_done_o)
);
